### hdl/assert_macros.svh
// Assertion macros shared by the checker files of the averaging block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("depth averaging assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("depth averaging assertion failed");

`endif

### hdl/mfda_pkg.sv
// Package for the multi-frame depth averaging block: sizes, codes, record types
// and the reciprocal table for the mean. No dependencies.
package mfda_pkg;

    localparam int MAX_FRAMES  = 4;
    localparam int DEPTH_BITS  = 16;
    localparam int COLOR_BITS  = 24;

    localparam int N_W         = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W       = DEPTH_BITS + $clog2(MAX_FRAMES);
    // Divisors stay below 8, so a shift of SUM_W + 3 keeps the scaled reciprocal exact.
    localparam int RECIP_SHIFT = SUM_W + 3;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int MODE_W      = 2;
    localparam int FIU_W       = 3;
    localparam int THR_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CMP_W       = (DEPTH_BITS > THR_W) ? DEPTH_BITS : THR_W;

    localparam int S_FIELDS_W  = MAX_FRAMES * (DEPTH_BITS + COLOR_BITS);
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = MAX_FRAMES;
    localparam int M_FIELDS_W  = DEPTH_BITS + COLOR_BITS + N_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE          = 2'd0,
        REG_FRAMES_IN_USE = 2'd1,
        REG_DEV_THRESHOLD = 2'd2
    } cfg_reg_e;

    typedef enum logic [MODE_W-1:0] {
        MODE_ANY        = 2'd0,
        MODE_ALL        = 2'd1,
        MODE_CONSISTENT = 2'd2
    } mode_e;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_ANY;
    localparam logic [FIU_W-1:0]  FIU_RESET  = 3'd4;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd120;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FIU_W-1:0]  frames_in_use;
        logic [THR_W-1:0]  dev_threshold;
    } cfg_t;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [MAX_FRAMES-1:0][DEPTH_BITS-1:0] depth;
        logic [COLOR_BITS-1:0]                 color_first;
        logic [COLOR_BITS-1:0]                 color_last;
        logic [MAX_FRAMES-1:0]                 check;
        logic [SUM_W-1:0]                      sum;
        logic [N_W-1:0]                        count;
        logic [N_W-1:0]                        frames;
        logic                                  single;
    } item_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth_out;
        logic [COLOR_BITS-1:0] color_out;
        logic                  kept;
        logic [N_W-1:0]        valid_count;
    } result_t;

    // Scaled reciprocal ceil(2^RECIP_SHIFT / c); zero for a count of zero.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [N_W-1:0] c);
        logic [63:0] one;
        logic [RECIP_W-1:0] r;
        one = 64'd1 << RECIP_SHIFT;
        unique case (int'(c))
            1:       r = RECIP_W'(one);
            2:       r = RECIP_W'((one + 64'd1) / 64'd2);
            3:       r = RECIP_W'((one + 64'd2) / 64'd3);
            4:       r = RECIP_W'((one + 64'd3) / 64'd4);
            5:       r = RECIP_W'((one + 64'd4) / 64'd5);
            6:       r = RECIP_W'((one + 64'd5) / 64'd6);
            7:       r = RECIP_W'((one + 64'd6) / 64'd7);
            8:       r = RECIP_W'((one + 64'd7) / 64'd8);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hdl/multi_frame_depth_average.sv
// Top level of the multi-frame depth averaging block: stream ports, configuration
// registers and the front, queue and back parts. Depends on mfda_pkg and its modules.

// One item is one pixel position seen in up to four aligned depth and colour frames.
// The block takes one item in every clock cycle while its queue is not full and hands
// out one result per item, in order. A result passes from the four-entry queue to
// the mean register and on to the output register, where it waits until the master
// side takes it. The sustained rate of one item per cycle is set by the single
// reciprocal multiplier in the back end, which finishes one mean per cycle. When the
// master side stalls, the output register, the mean register and the queue fill in
// turn, so up to six items may be taken before s_tready falls.
// The mean is the truncated quotient of the valid depths' sum and their count; a
// frame is valid when its depth is nonzero and its NaN bit is clear. The colour
// comes from the highest numbered valid frame. Mode 0 keeps a pixel with any valid
// frame, mode 1 only when every frame in use is valid, and mode 2 only when some
// frame is valid and every unflagged frame in use lies within the deviation
// threshold of the mean. With one frame in use, frame zero passes through unchanged.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata: index 0 is the
// mode (reset 0), index 1 the number of frames in use (reset 4) and index 2 the
// deviation threshold in eighths of a millimetre (reset 120). They should only be
// written while no item is in flight. No clearing pass follows reset.
module multi_frame_depth_average (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0 up: depth_0, depth_1, depth_2, depth_3,
    // color_0, color_1, color_2, color_3.
    input  logic [mfda_pkg::S_TDATA_W-1:0]      s_tdata,
    // From bit 0 up: nan_mask.
    input  logic [mfda_pkg::S_TUSER_W-1:0]      s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0 up: depth_out, color_out, valid_count, zero padding.
    output logic [mfda_pkg::M_TDATA_W-1:0]      m_tdata,
    // From bit 0 up: kept.
    output logic [mfda_pkg::M_TUSER_W-1:0]      m_tuser,

    input  logic                                cfg_wr_en,
    input  logic [mfda_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mfda_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mfda_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [FIU_W-1:0]  fiu_reg,  fiu_next;
    logic [THR_W-1:0]  thr_reg,  thr_next;
    cfg_t              cfg;

    logic [MAX_FRAMES-1:0][DEPTH_BITS-1:0] depth;
    logic [MAX_FRAMES-1:0][COLOR_BITS-1:0] color;

    logic    q_full;
    logic    q_push;
    item_t   push_item;
    logic    q_pop;
    logic    head_valid;
    item_t   head_item;
    result_t result;

    // Configuration writes; an index beyond the register list is ignored.
    always_comb begin
        mode_next = mode_reg;
        fiu_next  = fiu_reg;
        thr_next  = thr_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_addr))
                REG_MODE:          mode_next = cfg_wdata[MODE_W-1:0];
                REG_FRAMES_IN_USE: fiu_next  = cfg_wdata[FIU_W-1:0];
                REG_DEV_THRESHOLD: thr_next  = cfg_wdata[THR_W-1:0];
                default:           mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            fiu_reg  <= FIU_RESET;
            thr_reg  <= THR_RESET;
        end else begin
            mode_reg <= mode_next;
            fiu_reg  <= fiu_next;
            thr_reg  <= thr_next;
        end
    end

    always_comb begin
        cfg.mode          = mode_reg;
        cfg.frames_in_use = fiu_reg;
        cfg.dev_threshold = thr_reg;
    end

    // Unpack the slave payload into per-frame depths and colours.
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            depth[k] = s_tdata[k*DEPTH_BITS +: DEPTH_BITS];
            color[k] = s_tdata[MAX_FRAMES*DEPTH_BITS + k*COLOR_BITS +: COLOR_BITS];
        end
    end

    mfda_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .depth         (depth),
        .color         (color),
        .nan_mask      (s_tuser[MAX_FRAMES-1:0]),
        .frames_in_use (fiu_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    mfda_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mfda_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (head_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Pack the result; the padding above valid_count stays zero.
    always_comb begin
        m_tdata = '0;
        m_tdata[DEPTH_BITS-1:0]                       = result.depth_out;
        m_tdata[DEPTH_BITS +: COLOR_BITS]             = result.color_out;
        m_tdata[DEPTH_BITS + COLOR_BITS +: N_W]       = result.valid_count;
        m_tuser[0]                                    = result.kept;
    end

endmodule

### hdl/mfda_front.sv
// Front end: accepts pixels and classifies each frame, forming sum, count and colour.
// Depends on mfda_pkg.
module mfda_front (
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [mfda_pkg::MAX_FRAMES-1:0][mfda_pkg::DEPTH_BITS-1:0] depth,
    input  logic [mfda_pkg::MAX_FRAMES-1:0][mfda_pkg::COLOR_BITS-1:0] color,
    input  logic [mfda_pkg::MAX_FRAMES-1:0]               nan_mask,
    input  logic [mfda_pkg::FIU_W-1:0]                    frames_in_use,
    input  logic                                          q_full,
    output logic                                          q_push,
    output mfda_pkg::item_t                               q_item
);
    import mfda_pkg::*;

    logic [N_W-1:0]        n;
    logic [SUM_W-1:0]      sum;
    logic [N_W-1:0]        count;
    logic [COLOR_BITS-1:0] color_last;
    logic [MAX_FRAMES-1:0] check;
    logic                  frame_valid;

    // Out-of-range frame counts fold into 1 .. MAX_FRAMES.
    always_comb begin
        if (frames_in_use == '0) begin
            n = N_W'(1);
        end else if (int'(frames_in_use) > MAX_FRAMES) begin
            n = N_W'(MAX_FRAMES);
        end else begin
            n = N_W'(frames_in_use);
        end
    end

    always_comb begin
        sum         = '0;
        count       = '0;
        color_last  = '0;
        check       = '0;
        frame_valid = 1'b0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            check[k]    = (k < int'(n)) && !nan_mask[k];
            frame_valid = check[k] && (depth[k] != '0);
            if (frame_valid) begin
                sum        = sum + SUM_W'(depth[k]);
                count      = count + N_W'(1);
                color_last = color[k];
            end
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.depth       = depth;
        q_item.color_first = color[0];
        q_item.color_last  = color_last;
        q_item.check       = check;
        q_item.sum         = sum;
        q_item.count       = count;
        q_item.frames      = n;
        q_item.single      = (n == N_W'(1));
    end

endmodule

### hdl/mfda_queue.sv
// Short first-in first-out queue of classified pixels between front and back.
// Depends on mfda_pkg.
module mfda_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mfda_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mfda_pkg::item_t head_item
);
    import mfda_pkg::*;

    item_t                store_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg,  count_next;

    assign full       = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + Q_CNT_W'(1);
            2'b01:   count_next = count_reg - Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/mfda_back.sv
// Back end: mean by reciprocal multiply, mode acceptance and the output register.
// Depends on mfda_pkg.
module mfda_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfda_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  mfda_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mfda_pkg::result_t m_result
);
    import mfda_pkg::*;

    logic                  s1_valid_reg;
    item_t                 s1_item_reg;
    logic [DEPTH_BITS-1:0] s1_mean_reg;
    logic                  out_valid_reg;
    result_t               out_reg, out_next;

    logic                  out_ready;
    logic                  s1_ready;
    logic [PROD_W-1:0]     product;
    logic [DEPTH_BITS-1:0] mean_next;
    logic                  dev_fail;
    logic                  keep;
    logic [DEPTH_BITS-1:0] depth_gap;

    assign out_ready = !out_valid_reg || m_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = q_valid && s1_ready;

    // The mean is below 2^DEPTH_BITS, so the selected bits hold it whole.
    assign product   = PROD_W'(q_item.sum) * PROD_W'(recip_of(q_item.count));
    assign mean_next = product[RECIP_SHIFT +: DEPTH_BITS];

    always_comb begin
        dev_fail  = 1'b0;
        depth_gap = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            depth_gap = (s1_item_reg.depth[k] > s1_mean_reg) ?
                        s1_item_reg.depth[k] - s1_mean_reg :
                        s1_mean_reg - s1_item_reg.depth[k];
            if (s1_item_reg.check[k] &&
                (CMP_W'(depth_gap) > CMP_W'(cfg.dev_threshold))) begin
                dev_fail = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (cfg.mode)
            MODE_ALL:        keep = (s1_item_reg.count == s1_item_reg.frames);
            MODE_CONSISTENT: keep = (s1_item_reg.count != '0) && !dev_fail;
            default:         keep = (s1_item_reg.count != '0);
        endcase

        out_next.valid_count = s1_item_reg.count;
        if (s1_item_reg.single) begin
            out_next.depth_out = s1_item_reg.depth[0];
            out_next.color_out = s1_item_reg.color_first;
            out_next.kept      = 1'b1;
        end else begin
            out_next.depth_out = keep ? s1_mean_reg : '0;
            out_next.color_out = keep ? s1_item_reg.color_last : '0;
            out_next.kept      = keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (out_ready) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg <= q_item;
            s1_mean_reg <= mean_next;
        end
        if (out_ready && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

### hdl/mfda_checker.sv
// Port-level checker for the multi-frame depth averaging block, bound to the top.
// Depends on mfda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfda_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mfda_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [mfda_pkg::M_TUSER_W-1:0]  m_tuser
);
    import mfda_pkg::*;

    localparam int DC_W  = DEPTH_BITS + COLOR_BITS;

    // A result waiting on the master side must not change.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the pipeline: no result right after reset.
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // A rejected pixel carries zero depth and zero colour.
    `ASSERT_CLK(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[DC_W-1:0] == '0)

    // The reported count never exceeds the number of frames.
    `ASSERT_CLK(a_count_range, aclk, aresetn, m_tvalid |-> int'(m_tdata[DC_W +: N_W]) <= MAX_FRAMES)

endmodule

bind multi_frame_depth_average mfda_checker u_checker (.*);

### dv/mfda_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multi-frame depth averaging block: watches both streams and the
// register port, computes each pixel's expected average and compares. Uses mfda_pkg.
module mfda_scoreboard (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // From bit 0 up: depth_0 .. depth_3, color_0 .. color_3.
    input  logic [mfda_pkg::S_TDATA_W-1:0]      s_tdata,
    // From bit 0 up: nan_mask.
    input  logic [mfda_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0 up: depth_out, color_out, valid_count, zero padding.
    input  logic [mfda_pkg::M_TDATA_W-1:0]      m_tdata,
    // From bit 0 up: kept.
    input  logic [mfda_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [mfda_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mfda_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatches,
    output int                                  outstanding
);
    import mfda_pkg::*;

    localparam int COLOR_LSB = MAX_FRAMES * DEPTH_BITS;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [COLOR_BITS-1:0] color;
        logic                  kept;
        logic [N_W-1:0]        count;
    } pixel_result_t;

    logic [MODE_W-1:0] avg_mode;
    logic [FIU_W-1:0]  avg_frames;
    logic [THR_W-1:0]  avg_threshold;
    pixel_result_t     expected_q[$];
    int                fails = 0;

    function automatic pixel_result_t average_pixel(input logic [S_TDATA_W-1:0] data,
                                                    input logic [MAX_FRAMES-1:0] nan_mask);
        int                    frames;
        int                    k;
        logic [SUM_W-1:0]      sum;
        logic [N_W-1:0]        count;
        logic [DEPTH_BITS-1:0] depth;
        logic [DEPTH_BITS-1:0] mean;
        logic [DEPTH_BITS-1:0] depth_gap;
        logic [COLOR_BITS-1:0] color;
        logic                  keep;
        pixel_result_t         res;
        frames = int'(avg_frames);
        if (frames < 1) frames = 1;
        if (frames > MAX_FRAMES) frames = MAX_FRAMES;
        sum   = '0;
        count = '0;
        color = '0;
        mean  = '0;
        for (k = 0; k < frames; k++) begin
            depth = data[DEPTH_BITS*k +: DEPTH_BITS];
            if (depth != '0 && !nan_mask[k]) begin
                sum   = sum + SUM_W'(depth);
                count = count + N_W'(1);
                color = data[COLOR_LSB + COLOR_BITS*k +: COLOR_BITS];
            end
        end
        // A single frame goes through untouched, whatever its depth or flag.
        if (frames == 1) begin
            res.depth = data[DEPTH_BITS-1:0];
            res.color = data[COLOR_LSB +: COLOR_BITS];
            res.kept  = 1'b1;
            res.count = count;
            return res;
        end
        if (count != '0) mean = DEPTH_BITS'(sum / count);
        keep = (count != '0);
        if (avg_mode == MODE_ALL) begin
            keep = (int'(count) == frames);
        end else if (avg_mode == MODE_CONSISTENT) begin
            // Zero depths take part in the spread check; flagged frames do not.
            for (k = 0; k < frames; k++) begin
                if (!nan_mask[k]) begin
                    depth     = data[DEPTH_BITS*k +: DEPTH_BITS];
                    depth_gap = (depth > mean) ? depth - mean : mean - depth;
                    if (depth_gap > avg_threshold) keep = 1'b0;
                end
            end
        end
        res.depth = keep ? mean : '0;
        res.color = keep ? color : '0;
        res.kept  = keep;
        res.count = count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : watch
        pixel_result_t got;
        pixel_result_t want;
        if (!aresetn) begin
            avg_mode      = MODE_ANY;
            avg_frames    = 3'd4;
            avg_threshold = 16'd120;
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) expected_q.push_back(average_pixel(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                got.depth = m_tdata[DEPTH_BITS-1:0];
                got.color = m_tdata[DEPTH_BITS +: COLOR_BITS];
                got.count = m_tdata[DEPTH_BITS+COLOR_BITS +: N_W];
                got.kept  = m_tuser[0];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none got depth 0x%0h color 0x%0h",
                             $time, got.depth, got.color);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("depth_out", 32'(want.depth), 32'(got.depth));
                    check_field("color_out", 32'(want.color), 32'(got.color));
                    check_field("kept", 32'(want.kept), 32'(got.kept));
                    check_field("valid_count", 32'(want.count), 32'(got.count));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MODE:          avg_mode      = cfg_wdata[MODE_W-1:0];
                    REG_FRAMES_IN_USE: avg_frames    = cfg_wdata[FIU_W-1:0];
                    REG_DEV_THRESHOLD: avg_threshold = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches  <= fails;
        outstanding <= expected_q.size();
    end

endmodule

### dv/tb_multi_frame_depth_average.sv
`timescale 1ns / 100ps
// Testbench top for multi_frame_depth_average: clock, reset, register settings and
// pixel stimulus; checking is done by mfda_scoreboard. Uses mfda_pkg and both modules.
module tb_multi_frame_depth_average;
    import mfda_pkg::*;

    // Mode 3 is not a named mode of the block; it must behave like mode 0.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int N_PHASES      = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 400;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [FIU_W-1:0]  frames;
        logic [THR_W-1:0]  threshold;
        int                pixels;
    } phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int   mismatches;
    int   outstanding;
    int   pixels_sent = 0;
    int   cycle_count = 0;
    int   ready_gap   = 0;
    logic hold_off    = 1'b0;
    logic quiet_tail  = 1'b0;

    multi_frame_depth_average dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    mfda_scoreboard scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Offers one pixel and returns at the edge where it is taken. A random gap
    // may come first; otherwise s_tvalid stays high from the previous item.
    task automatic send_pixel(input logic [S_TDATA_W-1:0] data,
                              input logic [S_TUSER_W-1:0] nan_mask);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= nan_mask;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    // Waits until every pixel has its result, then lets the pipeline settle so that
    // nothing is in flight when the registers change.
    task automatic settle();
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers on back-to-back cycles.
    task automatic load_settings(input phase_t p);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= CFG_DATA_W'(p.mode);
        @(posedge aclk);
        cfg_addr  <= REG_FRAMES_IN_USE;
        cfg_wdata <= CFG_DATA_W'(p.frames);
        @(posedge aclk);
        cfg_addr  <= REG_DEV_THRESHOLD;
        cfg_wdata <= p.threshold;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hand-picked pixels: all empty, all at full scale, all flagged, an unflagged
    // zero among close depths, a flagged outlier, odd values near the limits, and
    // frame zero empty and flagged while the others agree.
    task automatic send_corners();
        send_pixel({96'h0, 64'h0}, 4'h0);
        send_pixel({{4{24'hFFFFFF}}, {4{16'hFFFF}}}, 4'h0);
        send_pixel({{4{24'hFFFFFF}}, {4{16'hFFFF}}}, 4'hF);
        send_pixel({24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h123456,
                    16'd960, 16'd1040, 16'd0, 16'd1000}, 4'b0000);
        send_pixel({24'hA5A5A5, 24'h5A5A5A, 24'hC3C3C3, 24'h3C3C3C,
                    16'd1000, 16'd5000, 16'd1000, 16'd1000}, 4'b0100);
        send_pixel({24'h800001, 24'h7FFFFE, 24'h010203, 24'hFEDCBA,
                    16'd1, 16'hFFFF, 16'd7, 16'd0}, 4'b1010);
        send_pixel({24'h111111, 24'h222222, 24'h333333, 24'h444444,
                    16'd2000, 16'd2001, 16'd1999, 16'd0}, 4'b0001);
    endtask

    // Builds one random pixel. Most are clusters around a common depth whose spread
    // is scaled to the threshold, so that the consistency rule both keeps and
    // rejects; the rest are noise and values pinned at the ends of the range.
    task automatic make_pixel(input int spread_hint, output logic [S_TDATA_W-1:0] data,
                              output logic [S_TUSER_W-1:0] nan_mask);
        int shape;
        int base;
        int spread;
        int value;
        int k;
        data     = '0;
        nan_mask = '0;
        shape    = $urandom_range(0, 9);
        for (k = 0; k < MAX_FRAMES; k++)
            data[MAX_FRAMES*DEPTH_BITS + COLOR_BITS*k +: COLOR_BITS] = COLOR_BITS'($urandom);
        if (shape <= 5) begin
            base = $urandom & ((1 << $urandom_range(3, 16)) - 1);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = spread_hint / 2;
                2:       spread = spread_hint * 2 + 2;
                default: spread = $urandom_range(0, 4096);
            endcase
            for (k = 0; k < MAX_FRAMES; k++) begin
                value = base + $urandom_range(0, spread) - spread / 2;
                if (value < 0) value = 0;
                if (value > 65535) value = 65535;
                if ($urandom_range(0, 7) == 0) value = 0;
                data[DEPTH_BITS*k +: DEPTH_BITS] = DEPTH_BITS'(value);
                nan_mask[k] = ($urandom_range(0, 5) == 0);
            end
        end else if (shape <= 7) begin
            for (k = 0; k < MAX_FRAMES; k++)
                data[DEPTH_BITS*k +: DEPTH_BITS] = DEPTH_BITS'($urandom);
            nan_mask = S_TUSER_W'($urandom);
        end else if (shape == 8) begin
            for (k = 0; k < MAX_FRAMES; k++) begin
                case ($urandom_range(0, 4))
                    0:       value = 0;
                    1:       value = 1;
                    2:       value = 65534;
                    3:       value = 65535;
                    default: value = $urandom_range(0, 65535);
                endcase
                data[DEPTH_BITS*k +: DEPTH_BITS] = DEPTH_BITS'(value);
            end
            nan_mask = S_TUSER_W'($urandom);
        end else begin
            for (k = 0; k < MAX_FRAMES; k++)
                data[DEPTH_BITS*k +: DEPTH_BITS] = DEPTH_BITS'($urandom);
        end
    endtask

    // The result side is ready most of the time, with short random stalls. During
    // the long hold-off it stays low, and in the final phase it never stalls.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (quiet_tail) begin
            m_tready <= 1'b1;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) ready_gap = $urandom_range(1, 6);
        end
    end

    // One long stall of the result side while pixels keep coming, so that the
    // queue and the output stages fill and s_tready has to drop.
    initial begin
        do @(posedge aclk); while (pixels_sent < HOLD_AFTER);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("multi_frame_depth_average verification failed");
        $finish;
    end

    initial begin : stimulus
        phase_t               plan[N_PHASES];
        logic [S_TDATA_W-1:0] data;
        logic [S_TUSER_W-1:0] nan_mask;
        int                   p;
        int                   i;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= '0;

        // The first phase runs on the reset values. Frame counts of 0 and above four
        // and the unused mode come later, as do both ends of the threshold.
        plan[0]  = '{MODE_ANY,        3'd4, 16'd120,   160};
        plan[1]  = '{MODE_ALL,        3'd4, 16'd120,   120};
        plan[2]  = '{MODE_CONSISTENT, 3'd4, 16'd120,   150};
        plan[3]  = '{MODE_CONSISTENT, 3'd3, 16'd0,     100};
        plan[4]  = '{MODE_CONSISTENT, 3'd2, 16'hFFFF,  100};
        plan[5]  = '{MODE_ANY,        3'd1, 16'd7,     100};
        plan[6]  = '{MODE_UNUSED,     3'd0, 16'd300,   100};
        plan[7]  = '{MODE_ALL,        3'd7, 16'd1000,  100};
        plan[8]  = '{MODE_CONSISTENT, 3'd5, 16'd2000,  120};
        plan[9]  = '{MODE_ALL,        3'd2, 16'd0,     100};
        plan[10] = '{MODE_CONSISTENT, 3'd4, THR_W'($urandom_range(0, 4095)), 150};
        plan[11] = '{MODE_ANY,        3'd3, 16'd500,   130};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                settle();
                load_settings(plan[p]);
            end
            if (p == N_PHASES - 1) quiet_tail <= 1'b1;
            if (p == 0 || p == 2 || p == 5) send_corners();
            for (i = 0; i < plan[p].pixels; i++) begin
                make_pixel(int'(plan[p].threshold), data, nan_mask);
                send_pixel(data, nan_mask);
            end
            s_tvalid <= 1'b0;
        end
        settle();

        if (mismatches == 0) begin
            $display("multi_frame_depth_average verification clean");
        end else begin
            $display("multi_frame_depth_average verification failed");
        end
        $finish;
    end

endmodule
